// ===== hdl/qewt_pkg.sv =====
// Package for the quoted, escaped word tokeniser: byte codes, widths, result kinds
// and the structs passed between the input register, the decoder and the top level.
// Depends on nothing.
package qewt_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COUNT_W = 15;
  localparam int unsigned LINE_W  = 16;

  // Capacity after reset, the saturation point of the word counter and the largest
  // length that is ever reported.
  localparam logic [COUNT_W-1:0] CAP_RESET  = 15'h4000;
  localparam logic [COUNT_W-1:0] COUNT_SAT  = 15'h7FFF;
  localparam logic [COUNT_W-1:0] LENGTH_CAP = 15'h4000;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_LOW_N  = 8'h6E;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_SPACE    = 2'd1,
    KIND_LINE     = 2'd2,
    KIND_DROPPED  = 2'd3
  } qewt_kind_e;

  typedef struct packed {
    logic [CHAR_W-1:0] text;
    logic              last;
  } qewt_item_t;

  typedef struct packed {
    logic               escape;
    logic               quoted;
    logic [COUNT_W-1:0] count;
    logic [LINE_W-1:0]  lines;
    logic               overflowed;
  } qewt_state_t;

  typedef struct packed {
    logic               valid;
    qewt_kind_e         kind;
    logic [CHAR_W-1:0]  character;
    logic [COUNT_W-1:0] length;
    logic [LINE_W-1:0]  line;
    logic               overflow;
  } qewt_result_t;

  // Reported length: the counter clipped to the largest word length.
  function automatic logic [COUNT_W-1:0] clip_length(input logic [COUNT_W-1:0] count);
    return (count < LENGTH_CAP) ? count : LENGTH_CAP;
  endfunction

endpackage

// ===== hdl/qewt_in_reg.sv =====
// Input register of the tokeniser: captures one word from the slave stream and holds
// it until the decoder consumes it. Depends on qewt_pkg.
module qewt_in_reg
  import qewt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [CHAR_W-1:0] s_axis_tdata,
  input  logic              s_axis_tlast,
  input  logic              advance_i,
  output logic              valid_o,
  output qewt_item_t        item_o
);

  logic       valid_q, valid_d;
  qewt_item_t item_q;

  // A new word may enter whenever the register is empty or is being drained.
  assign s_axis_tready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.text <= s_axis_tdata;
      item_q.last <= s_axis_tlast;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/qewt_decode.sv =====
// Decoder of the tokeniser: from one byte, the current state and the capacity it
// works out the next state and the result, if any. Depends on qewt_pkg.
module qewt_decode
  import qewt_pkg::*;
(
  input  qewt_item_t         item_i,
  input  qewt_state_t        state_i,
  input  logic [COUNT_W-1:0] cap_i,
  output qewt_state_t        state_o,
  output qewt_result_t       result_o
);

  logic               slot_full;
  logic [COUNT_W-1:0] count_inc;
  qewt_state_t        nxt;
  qewt_result_t       res;

  assign slot_full = (state_i.count >= cap_i);
  assign count_inc = (state_i.count < COUNT_SAT) ? state_i.count + 1'b1 : state_i.count;

  always_comb begin
    nxt = state_i;
    res = '0;

    if (item_i.text == CH_NUL || item_i.text == CH_NL) begin
      nxt.escape     = 1'b0;
      nxt.lines      = state_i.lines + 1'b1;
      res.valid      = 1'b1;
      res.kind       = KIND_LINE;
      res.length     = clip_length(state_i.count);
      res.overflow   = state_i.overflowed | slot_full;
      nxt.count      = '0;
      nxt.overflowed = 1'b0;
    end else if (state_i.escape) begin
      nxt.escape     = 1'b0;
      nxt.count      = count_inc;
      nxt.overflowed = state_i.overflowed | slot_full;
      res.valid      = 1'b1;
      res.kind       = KIND_CHAR;
      res.character  = (item_i.text == CH_LOW_N) ? CH_NL : item_i.text;
      res.length     = clip_length(count_inc);
      res.overflow   = state_i.overflowed | slot_full;
    end else if (item_i.text == CH_BSLASH) begin
      nxt.escape = 1'b1;
    end else if (item_i.text == CH_QUOTE) begin
      nxt.quoted = !state_i.quoted;
    end else if (item_i.text == CH_SPACE && !state_i.quoted) begin
      if (state_i.count != '0) begin
        res.valid      = 1'b1;
        res.kind       = KIND_SPACE;
        res.length     = clip_length(state_i.count);
        res.overflow   = state_i.overflowed | slot_full;
        nxt.count      = '0;
        nxt.overflowed = 1'b0;
      end else begin
        // A skipped leading space still checks its slot and may mark the next word.
        nxt.overflowed = state_i.overflowed | slot_full;
      end
    end else begin
      nxt.count      = count_inc;
      nxt.overflowed = state_i.overflowed | slot_full;
      res.valid      = 1'b1;
      res.kind       = KIND_CHAR;
      res.character  = item_i.text;
      res.length     = clip_length(count_inc);
      res.overflow   = state_i.overflowed | slot_full;
    end

    res.line = nxt.lines;

    if (item_i.last) begin
      if (!(res.valid && (res.kind == KIND_SPACE || res.kind == KIND_LINE))) begin
        if (nxt.count != '0) begin
          res.valid     = 1'b1;
          res.kind      = KIND_DROPPED;
          res.character = '0;
          res.length    = clip_length(nxt.count);
          res.overflow  = nxt.overflowed;
        end else begin
          res.valid = 1'b0;
        end
      end
      nxt = '0;
    end
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

// ===== hdl/quoted_escaped_word_tokenizer_core.sv =====
// Top level of the quoted, escaped word tokeniser: input register, decoder, state and
// result register. Depends on qewt_pkg, qewt_in_reg and qewt_decode.

// The block takes one text byte per word on the slave stream (tlast marks the last
// byte of a buffer) and takes one word per clock cycle while the master stream does
// not stall. A byte is decoded while it sits in the input register and its result
// is captured in the result register as the byte moves on. The same pass through the
// decoder also updates the tokeniser state (escape, quoting, word count, line count,
// overflow flag) before the next byte. Bytes that give no result (backslash, double
// quote, skipped space, a last byte with nothing pending) are consumed without a
// word on the output. The result register parts the two sides, so one new byte can
// still enter the input register while a finished result waits. token_capacity is
// written through cfg_we_i and cfg_wdata_i and is kept across buffers; it resets to
// 16384. The user must write it only while the block is idle; the block does not
// itself enforce this.
module quoted_escaped_word_tokenizer_core
  import qewt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration: token_capacity.
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  // Slave stream. tdata: text_byte [7:0]. tlast: end_of_buffer.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  input  logic               s_axis_tlast,
  // Master stream. tdata: character [7:0], word_length [22:8], line_number [38:23],
  // overflow [39]. tuser: kind [1:0].
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,
  output logic [1:0]         m_axis_tuser
);

  logic               in_valid;
  qewt_item_t         in_item;
  logic               advance;
  logic [COUNT_W-1:0] cap_q;
  qewt_state_t        state_q, state_d;
  qewt_result_t       result;
  logic               out_valid_q;
  qewt_result_t       out_q;

  // The decoded byte moves on when the result register is free or being emptied.
  assign advance = in_valid && (!out_valid_q || m_axis_tready);

  qewt_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .advance_i     (advance),
    .valid_o       (in_valid),
    .item_o        (in_item)
  );

  qewt_decode u_decode (
    .item_i   (in_item),
    .state_i  (state_q),
    .cap_i    (cap_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Tokeniser state, updated once for every decoded byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: the valid flag is control, the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= result.valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.overflow, out_q.line, out_q.length, out_q.character};
  assign m_axis_tuser  = out_q.kind;

`ifndef NO_ASSERTIONS
  // The last byte of a buffer leaves the tokeniser state cleared.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_item.last) |=> (state_q == '0))
    else $error("state not cleared after the last byte of a buffer");

  // A byte that gives no result must not leave a word on the output.
  a_silent_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !result.valid) |=> !out_valid_q)
    else $error("a silent byte produced an output word");

  // Reported word lengths never pass the length cap.
  a_length_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.length <= LENGTH_CAP))
    else $error("reported word length above the cap");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for quoted_escaped_word_tokenizer_core: directed and random text
// is streamed in, and every word on the output is compared against a local tokeniser model.
// Depends on qewt_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;
  import qewt_pkg::*;

  localparam int unsigned        CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned        LONG_HOLD      = 300;
  localparam int unsigned        SETTLE_CYCLES  = 4;
  localparam logic [COUNT_W-1:0] CAPACITY_MAX   = 15'd16384;
  localparam logic [COUNT_W-1:0] WORD_LEN_LIMIT = 15'd16384;
  localparam logic [COUNT_W-1:0] COUNT_TOP      = 15'h7FFF;

  typedef struct packed {
    qewt_kind_e         kind;
    logic [CHAR_W-1:0]  character;
    logic [COUNT_W-1:0] length;
    logic [LINE_W-1:0]  line;
    logic               overflow;
  } token_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata     = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [39:0]        m_axis_tdata;
  logic [1:0]         m_axis_tuser;

  // Tokeniser model state; the capacity survives the end of a buffer.
  logic [COUNT_W-1:0] room          = CAPACITY_MAX;
  logic               escaped       = 1'b0;
  logic               quoted        = 1'b0;
  logic [COUNT_W-1:0] word_len      = '0;
  logic [LINE_W-1:0]  lines_done    = '0;
  logic               word_overflow = 1'b0;

  token_t      expected_tokens[$];
  token_t      want_token;
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;
  bit          sender_idles    = 1'b1;
  bit          receiver_stalls = 1'b1;
  bit          hold_request    = 1'b0;

  quoted_escaped_word_tokenizer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // text_byte [7:0]
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // character [7:0], word_length [22:8], line [38:23],
                                     // overflow [39]
    .m_axis_tuser  (m_axis_tuser)    // kind [1:0]
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Any byte that the tokeniser treats as an ordinary word character.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_NL || b == CH_SPACE || b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] random_text_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return plain_byte();
    if (r < 62) return CH_SPACE;
    if (r < 70) return CH_BSLASH;
    if (r < 76) return CH_QUOTE;
    if (r < 82) return CH_LOW_N;
    if (r < 88) return $urandom_range(0, 1) ? CH_NL : CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [COUNT_W-1:0] shown_length();
    return (word_len < WORD_LEN_LIMIT) ? word_len : WORD_LEN_LIMIT;
  endfunction

  // Advances the model by one accepted byte and queues the word it gives, if any.
  function automatic void tokenise_byte(input logic [7:0] b, input logic last);
    token_t tok;
    logic   emits;
    tok   = '0;
    emits = 1'b1;
    if (b == CH_NUL || b == CH_NL) begin
      escaped    = 1'b0;
      lines_done = lines_done + 1'b1;
      if (word_len >= room) word_overflow = 1'b1;
      tok.kind      = KIND_LINE;
      tok.length    = shown_length();
      tok.overflow  = word_overflow;
      word_len      = '0;
      word_overflow = 1'b0;
    end else if (escaped || !(b == CH_BSLASH || b == CH_QUOTE || (b == CH_SPACE && !quoted))) begin
      tok.character = (escaped && b == CH_LOW_N) ? CH_NL : b;
      escaped       = 1'b0;
      if (word_len >= room) word_overflow = 1'b1;
      if (word_len != COUNT_TOP) word_len = word_len + 1'b1;
      tok.kind     = KIND_CHAR;
      tok.length   = shown_length();
      tok.overflow = word_overflow;
    end else if (b == CH_BSLASH) begin
      escaped = 1'b1;
      emits   = 1'b0;
    end else if (b == CH_QUOTE) begin
      quoted = !quoted;
      emits  = 1'b0;
    end else begin
      // An unquoted space checks its terminator slot even when it is skipped.
      if (word_len >= room) word_overflow = 1'b1;
      if (word_len != '0) begin
        tok.kind      = KIND_SPACE;
        tok.length    = shown_length();
        tok.overflow  = word_overflow;
        word_len      = '0;
        word_overflow = 1'b0;
      end else begin
        emits = 1'b0;
      end
    end
    // The last byte of a buffer reports a word still being built as dropped.
    if (last && !(emits && (tok.kind == KIND_SPACE || tok.kind == KIND_LINE))) begin
      emits         = (word_len != '0);
      tok.kind      = KIND_DROPPED;
      tok.character = '0;
      tok.length    = shown_length();
      tok.overflow  = word_overflow;
    end
    tok.line = lines_done;
    if (last) begin
      escaped       = 1'b0;
      quoted        = 1'b0;
      word_len      = '0;
      lines_done    = '0;
      word_overflow = 1'b0;
    end
    if (emits) expected_tokens.push_back(tok);
  endfunction

  // Offers one byte and returns at the rising edge at which it is taken.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = sender_idles ? idle_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(negedge clk_i);
    while (!s_axis_tready);
    @(posedge clk_i);
    tokenise_byte(b, last);
  endtask

  task automatic push_text(input string text, input logic last_at_end);
    for (int i = 0; i < text.len(); i++)
      push_byte(text[i], last_at_end && (i == text.len() - 1));
  endtask

  // Waits until every expected word has come out and the pipeline has emptied.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [COUNT_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    room   = value;
  endtask

  // Receiver: random stalls, and a long hold-off when one is requested.
  initial begin : ready_driver
    int unsigned stall;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (receiver_stalls && $urandom_range(0, 2) == 0) begin
        stall = idle_length();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void compare_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Values are stable at the falling edge; a word seen here is taken at the next rise.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_tokens.size() == 0) begin
        $error("word with no expectation: tuser %0d, tdata %h", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want_token = expected_tokens.pop_front();
        compare_field("kind", 16'(want_token.kind), 16'(m_axis_tuser));
        compare_field("character", 16'(want_token.character), 16'(m_axis_tdata[7:0]));
        compare_field("word_length", 16'(want_token.length), 16'(m_axis_tdata[22:8]));
        compare_field("line_number", want_token.line, m_axis_tdata[38:23]);
        compare_field("overflow", 16'(want_token.overflow), 16'(m_axis_tdata[39]));
      end
    end
  end

  // Leading and inner spaces, escapes, quoting and plain characters at both ends.
  task automatic test_word_syntax();
    push_text("  ab \\n\\\"", 1'b0);
    push_text("\"x y\" z", 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(CH_NUL, 1'b0);
  endtask

  // Empty lines, an escape cleared by a line end and quoting carried over one.
  task automatic test_line_ends();
    push_byte(CH_NL, 1'b0);
    push_text("\\", 1'b0);
    push_byte(CH_NL, 1'b0);
    push_text("\"q", 1'b0);
    push_byte(CH_NL, 1'b0);
    push_text(" r\"", 1'b0);
    push_byte(CH_NUL, 1'b0);
  endtask

  // Every way a buffer can end, including those that give nothing.
  task automatic test_buffer_ends();
    push_text("w ", 1'b1);
    push_text("v", 1'b1);
    push_text("u\\", 1'b1);
    push_text("\\", 1'b1);
    push_text("\"", 1'b1);
    push_text(" ", 1'b1);
    push_byte(CH_NUL, 1'b1);
  endtask

  task automatic test_capacity_limits();
    set_capacity(15'd2);
    push_text("ab abc ", 1'b0);
    push_byte(CH_NL, 1'b0);
    set_capacity(15'd1);
    push_text("q r", 1'b1);
    // With no room at all a skipped leading space already marks the next word.
    set_capacity('0);
    push_text(" x ", 1'b0);
    push_byte(CH_NUL, 1'b1);
    set_capacity(CAPACITY_MAX);
    push_text("ok", 1'b0);
    push_byte(CH_NL, 1'b1);
  endtask

  // The receiver holds off while bytes keep coming, so the block must stall its input.
  task automatic test_backpressure();
    sender_idles = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++) push_byte(plain_byte(), 1'b0);
    push_byte(CH_NL, 1'b1);
    sender_idles = 1'b1;
  endtask

  // One word that runs well past a small capacity, so every later character flags it.
  task automatic test_long_word();
    set_capacity(15'd16);
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    for (int i = 0; i < 30; i++) push_byte(plain_byte(), 1'b0);
    push_byte(CH_SPACE, 1'b1);
    drain();
  endtask

  // A run of line ends in one buffer, mixing NUL and newline, counted line by line.
  task automatic test_line_count();
    for (int i = 0; i < 24; i++) push_byte(i[0] ? CH_NUL : CH_NL, i == 23);
    drain();
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  task automatic test_random_text();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_capacity(15'($urandom_range(1, 4)));
        1: set_capacity(15'($urandom_range(5, 12)));
        2: set_capacity(15'($urandom_range(1, 16384)));
        default: begin
          set_capacity(CAPACITY_MAX);
          sender_idles    = 1'b0;
          receiver_stalls = 1'b0;
        end
      endcase
      for (int n = 0; n < 60; n++) push_byte(random_text_byte(), $urandom_range(0, 24) == 0);
    end
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_word_syntax();
    test_line_ends();
    test_buffer_ends();
    test_capacity_limits();
    test_backpressure();
    test_long_word();
    test_line_count();
    test_random_text();
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
